// ----- hw/rtl/rgb420_pkg.sv -----
package rgb420_pkg;

  localparam int NumPix = 4;

  localparam logic [17:0] LumaCoefR = 18'd257;
  localparam logic [17:0] LumaCoefG = 18'd504;
  localparam logic [17:0] LumaCoefB = 18'd98;
  localparam logic [17:0] HalfMilli = 18'd500;
  localparam logic [7:0]  LumaBase  = 8'd16;

  // floor(t / 1000) = (t * LumaRecip) >> LumaShift for every t below 2^18.
  localparam logic [18:0] LumaRecip = 19'd268436;
  localparam int          LumaShift = 28;

  localparam logic signed [19:0] CbCoefR = 20'sd148;
  localparam logic signed [19:0] CbCoefG = 20'sd291;
  localparam logic signed [19:0] CbCoefB = 20'sd439;
  localparam logic signed [19:0] CrCoefR = 20'sd439;
  localparam logic signed [19:0] CrCoefG = 20'sd368;
  localparam logic signed [19:0] CrCoefB = 20'sd71;

  localparam logic [17:0] Milli = 18'd1000;

  // Chroma sums at or above 256 * 4000 saturate to the top code.
  localparam logic signed [21:0] ChromaSatLimit = 22'sd1024000;
  localparam logic signed [21:0] ChromaRound    = 22'sd500;
  // floor(u / 125) = (u * ChromaRecip) >> ChromaShift for every u below 32000.
  localparam logic [15:0] ChromaRecip = 16'd33555;
  localparam int          ChromaShift = 22;

  localparam logic [7:0] ChromaMax = 8'd255;
  localparam logic [7:0] ChromaOffsetReset = 8'd128;

  localparam logic [0:0] RegChromaOffset = 1'b0;

  typedef struct packed {
    logic signed [19:0] cb;
    logic signed [19:0] cr;
  } rgb420_chroma_t;

endpackage

// ----- hw/rtl/rgb420_lane.sv -----
module rgb420_lane
  import rgb420_pkg::*;
(
  input  logic           clk,
  input  logic [7:0]     red,
  input  logic [7:0]     green,
  input  logic [7:0]     blue,
  input  logic [17:0]    offset_milli,
  output logic [7:0]     luma,
  output rgb420_chroma_t chroma_term
);

  logic [17:0]        luma_sum_nxt;
  logic [17:0]        luma_sum_r;
  logic [36:0]        luma_prod_nxt;
  logic [36:0]        luma_prod_r;
  logic [7:0]         luma_nxt;
  logic [7:0]         luma_r;
  logic signed [19:0] r_s;
  logic signed [19:0] g_s;
  logic signed [19:0] b_s;
  logic signed [19:0] off_s;
  rgb420_chroma_t     term_nxt;
  rgb420_chroma_t     term_r;

  always_comb begin
    r_s   = signed'({12'd0, red});
    g_s   = signed'({12'd0, green});
    b_s   = signed'({12'd0, blue});
    off_s = signed'({2'd0, offset_milli});
    luma_sum_nxt = 18'(red) * LumaCoefR + 18'(green) * LumaCoefG
                 + 18'(blue) * LumaCoefB + HalfMilli;
    term_nxt.cb = off_s - r_s * CbCoefR - g_s * CbCoefG + b_s * CbCoefB;
    term_nxt.cr = off_s + r_s * CrCoefR - g_s * CrCoefG - b_s * CrCoefB;
    luma_prod_nxt = 37'(luma_sum_r) * 37'(LumaRecip);
    luma_nxt = luma_prod_r[LumaShift +: 8] + LumaBase;
  end

  always_ff @(posedge clk) begin
    luma_sum_r  <= luma_sum_nxt;
    term_r      <= term_nxt;
    luma_prod_r <= luma_prod_nxt;
    luma_r      <= luma_nxt;
  end

  assign luma        = luma_r;
  assign chroma_term = term_r;

endmodule

// ----- hw/rtl/rgb420_merge.sv -----
module rgb420_merge
  import rgb420_pkg::*;
(
  input  logic           clk,
  input  rgb420_chroma_t terms [NumPix],
  output logic [7:0]     blue_chroma,
  output logic [7:0]     red_chroma
);

  logic signed [21:0] cb_sum_nxt;
  logic signed [21:0] cr_sum_nxt;
  logic signed [21:0] cb_sum_r;
  logic signed [21:0] cr_sum_r;
  logic [30:0]        cb_prod_nxt;
  logic [30:0]        cr_prod_nxt;
  logic [30:0]        cb_prod_r;
  logic [30:0]        cr_prod_r;
  logic               cb_zero_r;
  logic               cr_zero_r;
  logic               cb_sat_r;
  logic               cr_sat_r;

  always_comb begin
    cb_sum_nxt = ChromaRound;
    cr_sum_nxt = ChromaRound;
    for (int i = 0; i < NumPix; i++) begin
      cb_sum_nxt = cb_sum_nxt + 22'(terms[i].cb);
      cr_sum_nxt = cr_sum_nxt + 22'(terms[i].cr);
    end
    cb_prod_nxt = 31'(cb_sum_r[19:5]) * 31'(ChromaRecip);
    cr_prod_nxt = 31'(cr_sum_r[19:5]) * 31'(ChromaRecip);
  end

  always_ff @(posedge clk) begin
    cb_sum_r  <= cb_sum_nxt;
    cr_sum_r  <= cr_sum_nxt;
    cb_prod_r <= cb_prod_nxt;
    cr_prod_r <= cr_prod_nxt;
    cb_zero_r <= (cb_sum_r <= 22'sd0);
    cr_zero_r <= (cr_sum_r <= 22'sd0);
    cb_sat_r  <= (cb_sum_r >= ChromaSatLimit);
    cr_sat_r  <= (cr_sum_r >= ChromaSatLimit);
  end

  always_comb begin
    if (cb_zero_r) begin
      blue_chroma = 8'd0;
    end else if (cb_sat_r) begin
      blue_chroma = ChromaMax;
    end else begin
      blue_chroma = cb_prod_r[ChromaShift +: 8];
    end
    if (cr_zero_r) begin
      red_chroma = 8'd0;
    end else if (cr_sat_r) begin
      red_chroma = ChromaMax;
    end else begin
      red_chroma = cr_prod_r[ChromaShift +: 8];
    end
  end

endmodule

// ----- hw/rtl/rgb_block_to_ycbcr420.sv -----
// RGB to YCbCr 4:2:0 converter for one 2x2 pixel block, BT.601 studio range.
// Input channel: the twelve in_* color ports carry one block and are taken as
// an item at a rising edge where start is high and busy is low. busy is
// always low, so a new item may be offered in every cycle.
// Result channel: out_valid is high for exactly one cycle per item, with the
// four luma values and the block's Cb and Cr on the out_* ports in that
// cycle. The receiver cannot stall; results must be taken when shown.
// Throughput is one item per cycle. Four pixel lanes run in parallel, each
// with a two-stage multiply-by-reciprocal for luma, and a merge stage sums
// the chroma terms and divides them the same way, clamping to 0 and 255.
// The configuration port holds chroma_offset at byte address 0. A write
// completes when psel, penable and pwrite are high; pready is always high.
// Synchronous reset clears the pipeline valid bits, so no result appears
// after reset until a new item is accepted, and sets chroma_offset to 128.
module rgb_block_to_ycbcr420
  import rgb420_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [7:0]  in_red_top_left,
  input  logic [7:0]  in_green_top_left,
  input  logic [7:0]  in_blue_top_left,
  input  logic [7:0]  in_red_top_right,
  input  logic [7:0]  in_green_top_right,
  input  logic [7:0]  in_blue_top_right,
  input  logic [7:0]  in_red_bottom_left,
  input  logic [7:0]  in_green_bottom_left,
  input  logic [7:0]  in_blue_bottom_left,
  input  logic [7:0]  in_red_bottom_right,
  input  logic [7:0]  in_green_bottom_right,
  input  logic [7:0]  in_blue_bottom_right,
  output logic        out_valid,
  output logic [7:0]  out_luma_top_left,
  output logic [7:0]  out_luma_top_right,
  output logic [7:0]  out_luma_bottom_left,
  output logic [7:0]  out_luma_bottom_right,
  output logic [7:0]  out_blue_chroma,
  output logic [7:0]  out_red_chroma,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [7:0]     chroma_offset_r;
  logic [7:0]     chroma_offset_nxt;
  logic [17:0]    offset_milli;
  logic           cfg_write;
  logic [2:0]     valid_r;
  logic [2:0]     valid_nxt;
  logic           out_valid_r;
  logic [7:0]     pix_red   [NumPix];
  logic [7:0]     pix_green [NumPix];
  logic [7:0]     pix_blue  [NumPix];
  logic [7:0]     lane_luma [NumPix];
  rgb420_chroma_t lane_term [NumPix];
  logic [7:0]     merge_cb;
  logic [7:0]     merge_cr;
  logic [7:0]     luma_out_r [NumPix];
  logic [7:0]     cb_out_r;
  logic [7:0]     cr_out_r;

  assign busy   = 1'b0;
  assign pready = 1'b1;

  assign cfg_write = psel && penable && pwrite && pready;

  always_comb begin
    chroma_offset_nxt = chroma_offset_r;
    if (cfg_write && paddr[2] == RegChromaOffset) begin
      chroma_offset_nxt = pwdata[7:0];
    end
    prdata = 32'd0;
    if (paddr[2] == RegChromaOffset) begin
      prdata = {24'd0, chroma_offset_r};
    end
  end

  assign offset_milli = 18'(chroma_offset_r) * Milli;

  assign valid_nxt = {valid_r[1:0], start && !busy};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chroma_offset_r <= ChromaOffsetReset;
      valid_r         <= 3'd0;
      out_valid_r     <= 1'b0;
    end else begin
      chroma_offset_r <= chroma_offset_nxt;
      valid_r         <= valid_nxt;
      out_valid_r     <= valid_r[2];
    end
  end

  assign pix_red[0]   = in_red_top_left;
  assign pix_green[0] = in_green_top_left;
  assign pix_blue[0]  = in_blue_top_left;
  assign pix_red[1]   = in_red_top_right;
  assign pix_green[1] = in_green_top_right;
  assign pix_blue[1]  = in_blue_top_right;
  assign pix_red[2]   = in_red_bottom_left;
  assign pix_green[2] = in_green_bottom_left;
  assign pix_blue[2]  = in_blue_bottom_left;
  assign pix_red[3]   = in_red_bottom_right;
  assign pix_green[3] = in_green_bottom_right;
  assign pix_blue[3]  = in_blue_bottom_right;

  for (genvar i = 0; i < NumPix; i++) begin : g_lane
    rgb420_lane u_lane (
      .clk          (clk),
      .red          (pix_red[i]),
      .green        (pix_green[i]),
      .blue         (pix_blue[i]),
      .offset_milli (offset_milli),
      .luma         (lane_luma[i]),
      .chroma_term  (lane_term[i])
    );
  end

  rgb420_merge u_merge (
    .clk         (clk),
    .terms       (lane_term),
    .blue_chroma (merge_cb),
    .red_chroma  (merge_cr)
  );

  always_ff @(posedge clk) begin
    luma_out_r <= lane_luma;
    cb_out_r   <= merge_cb;
    cr_out_r   <= merge_cr;
  end

  assign out_valid             = out_valid_r;
  assign out_luma_top_left     = luma_out_r[0];
  assign out_luma_top_right    = luma_out_r[1];
  assign out_luma_bottom_left  = luma_out_r[2];
  assign out_luma_bottom_right = luma_out_r[3];
  assign out_blue_chroma       = cb_out_r;
  assign out_red_chroma        = cr_out_r;

`ifndef SYNTHESIS
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |-> ##4 out_valid)
    else $error("accepted item did not produce a result after four cycles");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(valid_r[2]))
    else $error("result strobe without an item in the last stage");

  a_luma_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_luma_top_left >= LumaBase && out_luma_top_left <= 8'd235
               && out_luma_bottom_right >= LumaBase && out_luma_bottom_right <= 8'd235)
    else $error("luma outside studio range");

  a_offset_write: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && !$stable(chroma_offset_r) |->
      $past(cfg_write) && $past(paddr[2]) == RegChromaOffset)
    else $error("chroma offset changed without a register write");
`endif

endmodule
